// File: design/vrd_pkg.sv
// shared constants, types and tables of the vector rotation block
package vrd_pkg;

    localparam int DATA_W          = 32;
    localparam int ROTATION_STAGES = 24;
    localparam int FRACTION_BITS   = 16;
    localparam int GUARD_BITS      = 24;
    localparam int PREP_STAGES     = 8;

    // gain prescale
    localparam int GAIN_SHIFT = DATA_W - GUARD_BITS;
    localparam int PROD_W     = 2 * DATA_W + 1;
    localparam int XW         = DATA_W + GUARD_BITS + 2;
    localparam int ZW         = 33;
    localparam logic signed [DATA_W:0]   GAIN      = (DATA_W + 1)'(64'd2608131496);
    localparam logic        [PROD_W-1:0] GAIN_BIAS = PROD_W'(1) << (GAIN_SHIFT - 1);

    // division by 45 through a reciprocal
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 27;
    localparam int REM_W       = 6;
    localparam logic [RECIP_W-1:0] RECIP_45 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd45);
    localparam logic [REM_W-1:0]   DIVISOR  = REM_W'(45);

    // angle reduction, 360 degrees is 45 * 2^(FRACTION_BITS + 3)
    localparam int DW      = 35;
    localparam int LO_BITS = FRACTION_BITS + 3;
    localparam int AHW     = DATA_W - LO_BITS;
    localparam int RMW     = AHW + 7;
    localparam int QPW     = AHW + RECIP_SHIFT - 4;
    localparam logic signed [DW-1:0] FULL_TURN    = DW'(longint'(360) << FRACTION_BITS);
    localparam logic signed [DW-1:0] HALF_TURN    = DW'(longint'(180) << FRACTION_BITS);
    localparam logic signed [DW-1:0] NEG_HALF     = -HALF_TURN;
    localparam logic signed [DW-1:0] QUARTER_TURN = DW'(longint'(90) << FRACTION_BITS);
    localparam logic signed [DW-1:0] NEG_QUARTER  = -QUARTER_TURN;

    // degrees to binary angle: round(d * 2^(32-F) / 360) as (d * 2^(29-F) + 22) / 45
    localparam int DDW = FRACTION_BITS + 7;
    localparam int DPW = DDW + RECIP_W;
    localparam int Q1W = DPW - RECIP_SHIFT;
    localparam int KSH = 29 - FRACTION_BITS;
    localparam int WW  = KSH + 6;
    localparam int WPW = WW + RECIP_W;
    localparam int Q2W = WPW - RECIP_SHIFT;
    localparam int ROUND_BIAS = 180 / 8;

    // output saturation
    localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    // occupancy bound: all pipeline stages plus output register and skid entry
    localparam int CAP   = PREP_STAGES + ROTATION_STAGES + 2;
    localparam int CNT_W = $clog2(CAP + 1);

    localparam int ATAN_W = 30;
    localparam logic [ATAN_W-1:0] ATAN_TABLE [0:31] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rot_item;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
    } t_vec_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic                     clipped;
    } t_out_item;

endpackage

// File: design/vrd_if.sv
// item channel interfaces of the vector rotation block
interface vrd_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [vrd_pkg::DATA_W-1:0] vec_x;
    logic signed [vrd_pkg::DATA_W-1:0] vec_y;
    logic signed [vrd_pkg::DATA_W-1:0] turn_degrees;

    modport source (output valid, vec_x, vec_y, turn_degrees, input ready);
    modport sink   (input valid, vec_x, vec_y, turn_degrees, output ready);
endinterface

interface vrd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vrd_pkg::DATA_W-1:0] rot_x;
    logic signed [vrd_pkg::DATA_W-1:0] rot_y;
    logic                              clipped;

    modport source (output valid, rot_x, rot_y, clipped, input ready);
    modport sink   (input valid, rot_x, rot_y, clipped, output ready);
endinterface

// File: design/vrd_prep.sv
// front end pipeline: gain prescale, angle reduction and quarter turn, binary angle
module vrd_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic signed [vrd_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [vrd_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [vrd_pkg::DATA_W-1:0] i_turn_degrees,
    output logic                              o_valid,
    output vrd_pkg::t_rot_item                o_item
);

    logic [vrd_pkg::PREP_STAGES-1:0] r_v;

    // stage 1
    logic        [vrd_pkg::DATA_W-1:0]  w_abs;
    logic signed [vrd_pkg::PROD_W-1:0]  w_px, w_py;
    logic        [vrd_pkg::QPW-1:0]     w_qp;
    logic signed [vrd_pkg::PROD_W-1:0]  r1_px, r1_py;
    logic        [vrd_pkg::QPW-1:0]     r1_qp;
    logic        [vrd_pkg::AHW-1:0]     r1_ahi;
    logic        [vrd_pkg::LO_BITS-1:0] r1_alo;
    logic                               r1_neg;

    // stage 2
    logic signed [vrd_pkg::PROD_W-1:0]  w_sx, w_sy;
    logic        [vrd_pkg::AHW-5:0]     w_q;
    logic        [vrd_pkg::RMW-1:0]     w_r0, w_rc;
    logic signed [vrd_pkg::XW-1:0]      r2_x, r2_y;
    logic        [vrd_pkg::REM_W-1:0]   r2_r;
    logic        [vrd_pkg::LO_BITS-1:0] r2_alo;
    logic                               r2_neg;

    // stage 3
    logic        [vrd_pkg::DW-1:0]      w_mag;
    logic signed [vrd_pkg::DW-1:0]      w_deg, w_wrap;
    logic signed [vrd_pkg::DW-1:0]      r3_deg;
    logic signed [vrd_pkg::XW-1:0]      r3_x, r3_y;

    // stage 4
    logic signed [vrd_pkg::DW-1:0]      w_qdeg, w_dabs;
    logic signed [vrd_pkg::XW-1:0]      w_qx, w_qy;
    logic        [vrd_pkg::DDW-1:0]     r4_d;
    logic                               r4_neg;
    logic signed [vrd_pkg::XW-1:0]      r4_x, r4_y;

    // stage 5
    logic        [vrd_pkg::DPW-1:0]     w_p5;
    logic        [vrd_pkg::DPW-1:0]     r5_p;
    logic        [vrd_pkg::DDW-1:0]     r5_d;
    logic                               r5_neg;
    logic signed [vrd_pkg::XW-1:0]      r5_x, r5_y;

    // stage 6
    logic        [vrd_pkg::Q1W-1:0]     w_q1;
    logic        [vrd_pkg::DDW-1:0]     w_m1, w_rem1;
    logic        [vrd_pkg::Q1W-1:0]     r6_q1;
    logic        [vrd_pkg::REM_W-1:0]   r6_r1;
    logic                               r6_neg;
    logic signed [vrd_pkg::XW-1:0]      r6_x, r6_y;

    // stage 7
    logic        [vrd_pkg::WW-1:0]      w_w;
    logic        [vrd_pkg::WPW-1:0]     w_p7;
    logic        [vrd_pkg::WW-1:0]      r7_w;
    logic        [vrd_pkg::WPW-1:0]     r7_p;
    logic        [vrd_pkg::Q1W-1:0]     r7_q1;
    logic                               r7_neg;
    logic signed [vrd_pkg::XW-1:0]      r7_x, r7_y;

    // stage 8
    logic        [vrd_pkg::Q2W-1:0]     w_q2, w_q2c;
    logic        [vrd_pkg::WW-1:0]      w_m2, w_rem2;
    logic        [vrd_pkg::ZW-1:0]      w_zmag;
    logic signed [vrd_pkg::ZW-1:0]      w_z;
    vrd_pkg::t_rot_item                 r8_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[vrd_pkg::PREP_STAGES-2:0], i_valid};
        end
    end

    // stage 1: magnitude of the angle, gain products, reciprocal of the turn count
    assign w_abs = i_turn_degrees[vrd_pkg::DATA_W-1] ? (vrd_pkg::DATA_W'(0) - $unsigned(i_turn_degrees))
                                                     : $unsigned(i_turn_degrees);
    assign w_px = $signed({{(vrd_pkg::DATA_W + 1){i_vec_x[vrd_pkg::DATA_W-1]}}, i_vec_x})
                * $signed({{vrd_pkg::DATA_W{1'b0}}, vrd_pkg::GAIN});
    assign w_py = $signed({{(vrd_pkg::DATA_W + 1){i_vec_y[vrd_pkg::DATA_W-1]}}, i_vec_y})
                * $signed({{vrd_pkg::DATA_W{1'b0}}, vrd_pkg::GAIN});
    assign w_qp = {{(vrd_pkg::QPW - vrd_pkg::AHW){1'b0}}, w_abs[vrd_pkg::DATA_W-1:vrd_pkg::LO_BITS]}
                * {{(vrd_pkg::QPW - vrd_pkg::RECIP_W){1'b0}}, vrd_pkg::RECIP_45};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_px  <= w_px;
            r1_py  <= w_py;
            r1_qp  <= w_qp;
            r1_ahi <= w_abs[vrd_pkg::DATA_W-1:vrd_pkg::LO_BITS];
            r1_alo <= w_abs[vrd_pkg::LO_BITS-1:0];
            r1_neg <= i_turn_degrees[vrd_pkg::DATA_W-1];
        end
    end

    // stage 2: round the prescaled vector, remainder of the turn count by 45
    assign w_sx = r1_px + $signed(vrd_pkg::GAIN_BIAS);
    assign w_sy = r1_py + $signed(vrd_pkg::GAIN_BIAS);
    assign w_q  = r1_qp[vrd_pkg::QPW-1:vrd_pkg::RECIP_SHIFT];
    assign w_r0 = {{(vrd_pkg::RMW - vrd_pkg::AHW){1'b0}}, r1_ahi}
                - {{(vrd_pkg::RMW - vrd_pkg::AHW + 4){1'b0}}, w_q}
                * {{(vrd_pkg::RMW - vrd_pkg::REM_W){1'b0}}, vrd_pkg::DIVISOR};
    assign w_rc = (w_r0 >= {{(vrd_pkg::RMW - vrd_pkg::REM_W){1'b0}}, vrd_pkg::DIVISOR})
                ? w_r0 - {{(vrd_pkg::RMW - vrd_pkg::REM_W){1'b0}}, vrd_pkg::DIVISOR} : w_r0;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_x   <= {w_sx[vrd_pkg::PROD_W-1], w_sx[vrd_pkg::PROD_W-1:vrd_pkg::GAIN_SHIFT]};
            r2_y   <= {w_sy[vrd_pkg::PROD_W-1], w_sy[vrd_pkg::PROD_W-1:vrd_pkg::GAIN_SHIFT]};
            r2_r   <= w_rc[vrd_pkg::REM_W-1:0];
            r2_alo <= r1_alo;
            r2_neg <= r1_neg;
        end
    end

    // stage 3: signed remainder, wrap into (-180, 180]
    assign w_mag = {{(vrd_pkg::DW - vrd_pkg::REM_W - vrd_pkg::LO_BITS){1'b0}}, r2_r, r2_alo};
    assign w_deg = r2_neg ? -$signed(w_mag) : $signed(w_mag);

    always_comb begin
        if (w_deg > vrd_pkg::HALF_TURN) begin
            w_wrap = w_deg - vrd_pkg::FULL_TURN;
        end else if (w_deg <= vrd_pkg::NEG_HALF) begin
            w_wrap = w_deg + vrd_pkg::FULL_TURN;
        end else begin
            w_wrap = w_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_deg <= w_wrap;
            r3_x   <= r2_x;
            r3_y   <= r2_y;
        end
    end

    // stage 4: exact quarter turn, angle magnitude
    always_comb begin
        if (r3_deg > vrd_pkg::QUARTER_TURN) begin
            w_qx   = -r3_y;
            w_qy   = r3_x;
            w_qdeg = r3_deg - vrd_pkg::QUARTER_TURN;
        end else if (r3_deg < vrd_pkg::NEG_QUARTER) begin
            w_qx   = r3_y;
            w_qy   = -r3_x;
            w_qdeg = r3_deg + vrd_pkg::QUARTER_TURN;
        end else begin
            w_qx   = r3_x;
            w_qy   = r3_y;
            w_qdeg = r3_deg;
        end
    end

    assign w_dabs = w_qdeg[vrd_pkg::DW-1] ? -w_qdeg : w_qdeg;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_d   <= w_dabs[vrd_pkg::DDW-1:0];
            r4_neg <= w_qdeg[vrd_pkg::DW-1];
            r4_x   <= w_qx;
            r4_y   <= w_qy;
        end
    end

    // stage 5: first reciprocal product
    assign w_p5 = {{(vrd_pkg::DPW - vrd_pkg::DDW){1'b0}}, r4_d}
                * {{(vrd_pkg::DPW - vrd_pkg::RECIP_W){1'b0}}, vrd_pkg::RECIP_45};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_p   <= w_p5;
            r5_d   <= r4_d;
            r5_neg <= r4_neg;
            r5_x   <= r4_x;
            r5_y   <= r4_y;
        end
    end

    // stage 6: quotient and remainder of the angle by 45
    assign w_q1   = r5_p[vrd_pkg::DPW-1:vrd_pkg::RECIP_SHIFT];
    assign w_m1   = {{(vrd_pkg::DDW - vrd_pkg::Q1W){1'b0}}, w_q1}
                  * {{(vrd_pkg::DDW - vrd_pkg::REM_W){1'b0}}, vrd_pkg::DIVISOR};
    assign w_rem1 = r5_d - w_m1;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_rem1 >= {{(vrd_pkg::DDW - vrd_pkg::REM_W){1'b0}}, vrd_pkg::DIVISOR}) begin
                r6_q1 <= w_q1 + vrd_pkg::Q1W'(1);
                r6_r1 <= w_rem1[vrd_pkg::REM_W-1:0] - vrd_pkg::DIVISOR;
            end else begin
                r6_q1 <= w_q1;
                r6_r1 <= w_rem1[vrd_pkg::REM_W-1:0];
            end
            r6_neg <= r5_neg;
            r6_x   <= r5_x;
            r6_y   <= r5_y;
        end
    end

    // stage 7: scaled remainder plus rounding bias, second reciprocal product
    assign w_w  = ({{(vrd_pkg::WW - vrd_pkg::REM_W){1'b0}}, r6_r1} << vrd_pkg::KSH)
                + vrd_pkg::WW'(vrd_pkg::ROUND_BIAS);
    assign w_p7 = {{(vrd_pkg::WPW - vrd_pkg::WW){1'b0}}, w_w}
                * {{(vrd_pkg::WPW - vrd_pkg::RECIP_W){1'b0}}, vrd_pkg::RECIP_45};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r7_w   <= w_w;
            r7_p   <= w_p7;
            r7_q1  <= r6_q1;
            r7_neg <= r6_neg;
            r7_x   <= r6_x;
            r7_y   <= r6_y;
        end
    end

    // stage 8: binary angle with its sign
    assign w_q2   = r7_p[vrd_pkg::WPW-1:vrd_pkg::RECIP_SHIFT];
    assign w_m2   = {{(vrd_pkg::WW - vrd_pkg::Q2W){1'b0}}, w_q2}
                  * {{(vrd_pkg::WW - vrd_pkg::REM_W){1'b0}}, vrd_pkg::DIVISOR};
    assign w_rem2 = r7_w - w_m2;
    assign w_q2c  = (w_rem2 >= {{(vrd_pkg::WW - vrd_pkg::REM_W){1'b0}}, vrd_pkg::DIVISOR})
                  ? w_q2 + vrd_pkg::Q2W'(1) : w_q2;
    assign w_zmag = ({{(vrd_pkg::ZW - vrd_pkg::Q1W){1'b0}}, r7_q1} << vrd_pkg::KSH)
                  + {{(vrd_pkg::ZW - vrd_pkg::Q2W){1'b0}}, w_q2c};
    assign w_z    = r7_neg ? -$signed(w_zmag) : $signed(w_zmag);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r8_item.x <= r7_x;
            r8_item.y <= r7_y;
            r8_item.z <= w_z;
        end
    end

    assign o_valid = r_v[vrd_pkg::PREP_STAGES-1];
    assign o_item  = r8_item;

endmodule

// File: design/vrd_cordic.sv
// cordic rotation pipeline, one micro-rotation per register stage
module vrd_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  vrd_pkg::t_rot_item i_item,
    output logic               o_valid,
    output vrd_pkg::t_vec_item o_item
);

    logic [vrd_pkg::ROTATION_STAGES-1:0] r_v;
    vrd_pkg::t_rot_item                  r_st [vrd_pkg::ROTATION_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[vrd_pkg::ROTATION_STAGES-2:0], i_valid};
        end
    end

    for (genvar g = 0; g < vrd_pkg::ROTATION_STAGES; g++) begin : g_stage
        vrd_pkg::t_rot_item            w_src;
        vrd_pkg::t_rot_item            w_nxt;
        logic signed [vrd_pkg::XW-1:0] w_dx;
        logic signed [vrd_pkg::XW-1:0] w_dy;
        logic signed [vrd_pkg::ZW-1:0] w_ang;

        if (g == 0) begin : g_first
            assign w_src = i_item;
        end else begin : g_rest
            assign w_src = r_st[g-1];
        end

        assign w_dx  = $signed(w_src.y) >>> g;
        assign w_dy  = $signed(w_src.x) >>> g;
        assign w_ang = $signed({{(vrd_pkg::ZW - vrd_pkg::ATAN_W){1'b0}}, vrd_pkg::ATAN_TABLE[g]});

        always_comb begin
            if (!w_src.z[vrd_pkg::ZW-1]) begin
                w_nxt.x = w_src.x - w_dx;
                w_nxt.y = w_src.y + w_dy;
                w_nxt.z = w_src.z - w_ang;
            end else begin
                w_nxt.x = w_src.x + w_dx;
                w_nxt.y = w_src.y - w_dy;
                w_nxt.z = w_src.z + w_ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[g] <= w_nxt;
            end
        end
    end

    assign o_valid  = r_v[vrd_pkg::ROTATION_STAGES-1];
    assign o_item.x = r_st[vrd_pkg::ROTATION_STAGES-1].x;
    assign o_item.y = r_st[vrd_pkg::ROTATION_STAGES-1].y;

endmodule

// File: design/vrd_out.sv
// output rounding and saturation with output register and one skid entry
module vrd_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  vrd_pkg::t_vec_item i_item,
    output logic               o_adv,
    output logic               o_valid,
    input  logic               i_ready,
    output vrd_pkg::t_out_item o_item
);

    localparam int RDW = vrd_pkg::XW - vrd_pkg::GUARD_BITS;

    logic signed [vrd_pkg::XW-1:0] w_sx, w_sy;
    logic signed [RDW-1:0]         w_rx, w_ry;
    logic                          w_ovx, w_ovy;
    vrd_pkg::t_out_item            w_res;
    logic                          w_in;
    logic                          w_take;
    logic                          r_out_v;
    logic                          r_skid_v;
    vrd_pkg::t_out_item            r_out;
    vrd_pkg::t_out_item            r_skid;

    // round to nearest, ties up
    assign w_sx = i_item.x + $signed(vrd_pkg::XW'(1) << (vrd_pkg::GUARD_BITS - 1));
    assign w_sy = i_item.y + $signed(vrd_pkg::XW'(1) << (vrd_pkg::GUARD_BITS - 1));
    assign w_rx = w_sx[vrd_pkg::XW-1:vrd_pkg::GUARD_BITS];
    assign w_ry = w_sy[vrd_pkg::XW-1:vrd_pkg::GUARD_BITS];

    // out of range when the bits above the result are not all sign
    assign w_ovx = (w_rx[RDW-1:vrd_pkg::DATA_W-1] != {(RDW - vrd_pkg::DATA_W + 1){w_rx[RDW-1]}});
    assign w_ovy = (w_ry[RDW-1:vrd_pkg::DATA_W-1] != {(RDW - vrd_pkg::DATA_W + 1){w_ry[RDW-1]}});

    always_comb begin
        if (w_ovx) begin
            w_res.rot_x = w_rx[RDW-1] ? vrd_pkg::OUT_MIN : vrd_pkg::OUT_MAX;
        end else begin
            w_res.rot_x = w_rx[vrd_pkg::DATA_W-1:0];
        end
        if (w_ovy) begin
            w_res.rot_y = w_ry[RDW-1] ? vrd_pkg::OUT_MIN : vrd_pkg::OUT_MAX;
        end else begin
            w_res.rot_y = w_ry[vrd_pkg::DATA_W-1:0];
        end
        w_res.clipped = w_ovx | w_ovy;
    end

    assign o_adv  = !r_skid_v;
    assign w_in   = i_valid && !r_skid_v;
    assign w_take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || w_take) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= w_in;
                end
            end else if (w_in) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (w_in) begin
                r_out <= w_res;
            end
        end else if (w_in) begin
            r_skid <= w_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

// File: design/vector_rotate_degrees_top.sv
// top level of the two-dimensional vector rotation block
// Rotates (vec_x, vec_y) counter-clockwise by turn_degrees, all signed Q16.16. One item
// enters per clock cycle while input ready is high. Every accepted item passes through an
// 8-stage front end (gain prescale, modulo-360 reduction, wrap, quarter turn, degree to
// binary angle conversion), one register stage per CORDIC micro-rotation, and the output
// register. A one-entry skid buffer behind the output register keeps input ready high
// while a finished result waits; ready drops only when the skid entry is also full.
// Results are rounded, saturated to 32 bits, and clipped is set when either saturated.
module vector_rotate_degrees_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vrd_in_if.sink    i_in,
    vrd_out_if.source o_out
);

    logic                         w_adv;
    logic                         w_prep_v;
    vrd_pkg::t_rot_item           w_prep_item;
    logic                         w_rot_v;
    vrd_pkg::t_vec_item           w_rot_item;
    logic                         w_out_v;
    vrd_pkg::t_out_item           w_out_item;
    logic                         w_acc_in;
    logic                         w_acc_out;
    logic [vrd_pkg::CNT_W-1:0]    r_count;
    logic [vrd_pkg::CNT_W-1:0]    n_count;

    assign i_in.ready = w_adv;

    vrd_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (i_in.valid),
        .i_vec_x        (i_in.vec_x),
        .i_vec_y        (i_in.vec_y),
        .i_turn_degrees (i_in.turn_degrees),
        .o_valid        (w_prep_v),
        .o_item         (w_prep_item)
    );

    vrd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_prep_v),
        .i_item  (w_prep_item),
        .o_valid (w_rot_v),
        .o_item  (w_rot_item)
    );

    vrd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rot_v),
        .i_item  (w_rot_item),
        .o_adv   (w_adv),
        .o_valid (w_out_v),
        .i_ready (o_out.ready),
        .o_item  (w_out_item)
    );

    assign o_out.valid   = w_out_v;
    assign o_out.rot_x   = w_out_item.rot_x;
    assign o_out.rot_y   = w_out_item.rot_y;
    assign o_out.clipped = w_out_item.clipped;

    // items in flight
    assign w_acc_in  = i_in.valid && w_adv;
    assign w_acc_out = w_out_v && o_out.ready;
    assign n_count   = r_count + {{(vrd_pkg::CNT_W - 1){1'b0}}, w_acc_in}
                               - {{(vrd_pkg::CNT_W - 1){1'b0}}, w_acc_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= vrd_pkg::CNT_W'(vrd_pkg::CAP))
        else $error("more items in flight than pipeline capacity");

    a_out_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_v |-> (r_count != '0))
        else $error("result offered with no item in flight");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == vrd_pkg::CNT_W'(vrd_pkg::CAP)) |-> !w_adv)
        else $error("input ready while every stage holds an item");

    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_v && w_out_item.clipped) |->
            (w_out_item.rot_x == vrd_pkg::OUT_MAX || w_out_item.rot_x == vrd_pkg::OUT_MIN ||
             w_out_item.rot_y == vrd_pkg::OUT_MAX || w_out_item.rot_y == vrd_pkg::OUT_MIN))
        else $error("clipped item without a saturated component");

endmodule
